// ----- design/fmb_pkg.sv -----
`default_nettype none
package fmb_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // A header expands to at most eight bytes: sync, sync, class, id, len lo,
  // len hi, and the two checksum bytes when the length is zero.
  localparam int BURST_DEPTH = 8;
  localparam int BURST_IDX_W = $clog2(BURST_DEPTH);

  localparam logic [BURST_IDX_W-1:0] LAST_HEADER_OPEN   = BURST_IDX_W'(5);
  localparam logic [BURST_IDX_W-1:0] LAST_HEADER_CLOSED = BURST_IDX_W'(7);
  localparam logic [BURST_IDX_W-1:0] LAST_PAYLOAD_OPEN  = BURST_IDX_W'(0);
  localparam logic [BURST_IDX_W-1:0] LAST_PAYLOAD_CLOSED = BURST_IDX_W'(2);

  typedef logic [7:0] byte_t;

endpackage
`default_nettype wire

// ----- design/framed_message_builder_fletcher8.sv -----
`default_nettype none
// Frame builder with an 8-bit Fletcher checksum. A header beat (opcode 0)
// produces the sync bytes 0xB5 0x62, class, id, length low and length high
// on the byte output; with a zero length the two checksum bytes and the end
// mark follow at once. A payload beat (opcode 1) produces its byte, and the
// last one of a frame also produces checksum A and checksum B, with
// frame_end set on B. Payload beats outside a frame are taken and dropped,
// and a header abandons any open frame. The output side moves one byte per
// cycle through a single output register while out_stall is low, so each
// beat holds the input until the last of its bytes is handed over (six or
// eight for a header); a dropped beat produces no bytes and does not hold it.
// in_stall is driven combinationally from out_stall so that the next beat
// is taken in the cycle the current burst hands over its last byte.
module framed_message_builder_fletcher8 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [7:0]         msg_class,
  input  wire logic [7:0]         msg_id,
  input  wire logic [15:0]        payload_length,
  input  wire logic [7:0]         payload_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fmb_pkg::byte_t          tx_byte,
  output logic                    frame_end
);
  import fmb_pkg::*;

  typedef logic [BURST_IDX_W-1:0] idx_t;

  // Running frame state.
  byte_t       sum_a;
  byte_t       sum_b;
  logic [15:0] bytes_left;
  logic        in_frame;

  // Burst of output bytes produced by the beat most recently taken.
  byte_t burst_bytes [BURST_DEPTH];
  logic  burst_active;
  logic  burst_close;
  idx_t  burst_last;
  idx_t  idx;

  logic  in_acc;
  logic  move;
  logic  is_last;

  // Next values computed from the incoming beat.
  byte_t       sum_a_next;
  byte_t       sum_b_next;
  logic [15:0] bytes_left_next;
  logic        in_frame_next;
  logic        emits;
  logic        close;
  idx_t        last_next;
  byte_t       load_bytes [BURST_DEPTH];

  byte_t       ha1, ha2, ha3, ha4;
  byte_t       hb1, hb2, hb3, hb4;
  byte_t       pa, pb;
  logic [15:0] left_dec;

  assign is_last  = (idx == burst_last);
  assign move     = burst_active && (!out_valid || !out_stall);
  assign in_stall = burst_active && !(move && is_last);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    // Header checksum: four dependent byte steps.
    ha1 = msg_class;
    hb1 = msg_class;
    ha2 = ha1 + msg_id;
    hb2 = hb1 + ha2;
    ha3 = ha2 + payload_length[7:0];
    hb3 = hb2 + ha3;
    ha4 = ha3 + payload_length[15:8];
    hb4 = hb3 + ha4;

    pa = sum_a + payload_byte;
    pb = sum_b + pa;
    left_dec = (bytes_left != 16'd0) ? bytes_left - 16'd1 : bytes_left;

    for (int i = 0; i < BURST_DEPTH; i++) begin
      load_bytes[i] = 8'h00;
    end

    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    bytes_left_next = bytes_left;
    in_frame_next   = in_frame;
    emits           = 1'b0;
    close           = 1'b0;
    last_next       = LAST_PAYLOAD_OPEN;

    case (opcode)
      OP_HEADER: begin
        close         = (payload_length == 16'd0);
        emits         = 1'b1;
        sum_a_next    = ha4;
        sum_b_next    = hb4;
        load_bytes[0] = SYNC_FIRST;
        load_bytes[1] = SYNC_SECOND;
        load_bytes[2] = msg_class;
        load_bytes[3] = msg_id;
        load_bytes[4] = payload_length[7:0];
        load_bytes[5] = payload_length[15:8];
        load_bytes[6] = ha4;
        load_bytes[7] = hb4;
        last_next       = close ? LAST_HEADER_CLOSED : LAST_HEADER_OPEN;
        bytes_left_next = payload_length;
        in_frame_next   = !close;
      end
      OP_PAYLOAD: begin
        if (in_frame) begin
          close           = (left_dec == 16'd0);
          emits           = 1'b1;
          sum_a_next      = pa;
          sum_b_next      = pb;
          load_bytes[0]   = payload_byte;
          load_bytes[1]   = pa;
          load_bytes[2]   = pb;
          last_next       = close ? LAST_PAYLOAD_CLOSED : LAST_PAYLOAD_OPEN;
          bytes_left_next = left_dec;
          in_frame_next   = !close;
        end
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a        <= 8'h00;
      sum_b        <= 8'h00;
      bytes_left   <= 16'd0;
      in_frame     <= 1'b0;
      burst_active <= 1'b0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // A beat is only taken while the burst hands over its last byte,
      // so a new load always wins over the index step.
      if (in_acc) begin
        burst_active <= emits;
        idx          <= '0;
        sum_a        <= sum_a_next;
        sum_b        <= sum_b_next;
        bytes_left   <= bytes_left_next;
        in_frame     <= in_frame_next;
      end else if (move) begin
        if (is_last) begin
          burst_active <= 1'b0;
        end else begin
          idx <= idx + idx_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      tx_byte   <= burst_bytes[idx];
      frame_end <= burst_close && is_last;
    end
    if (in_acc) begin
      burst_bytes <= load_bytes;
      burst_close <= close;
      burst_last  <= last_next;
    end
  end

  a_frame_has_bytes_left: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> bytes_left != 16'd0)
    else $error("open frame with no payload bytes left");

  a_header_burst_len: assert property (@(posedge clk) disable iff (rst)
    in_acc && opcode == OP_HEADER |=> burst_active &&
      (burst_last == LAST_HEADER_OPEN || burst_last == LAST_HEADER_CLOSED))
    else $error("header beat did not start a six or eight byte burst");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> idx <= burst_last)
    else $error("burst index ran past the last byte");

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import fmb_pkg::*;

  localparam int ITEM_TARGET  = 100;
  localparam int CALM_ITEMS   = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } tx_beat_t;

  // One directed beat. When typed is set, the first n_typed bytes of
  // typed_tx (lowest byte first) are the bytes to expect, and typed_last
  // marks frame_end on the last of them.
  typedef struct packed {
    logic        typed;
    logic [3:0]  n_typed;
    logic [63:0] typed_tx;
    logic        typed_last;
    logic        op;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  pb;
  } stim_row_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        opcode         = OP_HEADER;
  logic [7:0]  msg_class      = 8'h00;
  logic [7:0]  msg_id         = 8'h00;
  logic [15:0] payload_length = 16'h0000;
  logic [7:0]  payload_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  byte_t       tx_byte;
  logic        frame_end;

  framed_message_builder_fletcher8 u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .msg_class      (msg_class),
    .msg_id         (msg_id),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_byte        (tx_byte),
    .frame_end      (frame_end)
  );

  always #1 clk = ~clk;

  // Running frame state of the checksum predictor.
  logic [7:0]  fl_a    = 8'h00;
  logic [7:0]  fl_b    = 8'h00;
  logic [15:0] fl_left = 16'h0000;
  logic        fl_open = 1'b0;

  tx_beat_t  tx_expected_q[$];
  stim_row_t dir_rows[$];
  int        errors      = 0;
  int        beats_in    = 0;
  int        idle_cycles = 0;
  bit        calm        = 1'b0;
  bit        hold_on     = 1'b0;
  bit        held_long   = 1'b0;

  task automatic queue_tx(input logic [7:0] b, input logic last, input bit keep,
                          inout int n);
    if (keep) tx_expected_q.push_back('{b, last});
    n++;
  endtask

  task automatic fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endtask

  task automatic close_checksum(input bit keep, inout int n);
    queue_tx(fl_a, 1'b0, keep, n);
    queue_tx(fl_b, 1'b1, keep, n);
    fl_open = 1'b0;
    fl_left = 16'h0000;
  endtask

  // Works out the frame bytes that one accepted beat produces; n returns
  // how many there are. With keep low only the frame state advances.
  task automatic predict_frame_bytes(input logic op, input logic [7:0] cls,
                                     input logic [7:0] id, input logic [15:0] len,
                                     input logic [7:0] pb, input bit keep,
                                     output int n);
    n = 0;
    if (op == OP_HEADER) begin
      fl_a = 8'h00;
      fl_b = 8'h00;
      queue_tx(SYNC_FIRST, 1'b0, keep, n);
      queue_tx(SYNC_SECOND, 1'b0, keep, n);
      queue_tx(cls, 1'b0, keep, n);
      fletcher_add(cls);
      queue_tx(id, 1'b0, keep, n);
      fletcher_add(id);
      queue_tx(len[7:0], 1'b0, keep, n);
      fletcher_add(len[7:0]);
      queue_tx(len[15:8], 1'b0, keep, n);
      fletcher_add(len[15:8]);
      fl_left = len;
      fl_open = 1'b1;
      if (len == 16'h0000) close_checksum(keep, n);
    end else if (fl_open) begin
      queue_tx(pb, 1'b0, keep, n);
      fletcher_add(pb);
      if (fl_left != 16'h0000) fl_left = fl_left - 16'h0001;
      if (fl_left == 16'h0000) close_checksum(keep, n);
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] cls, input logic [7:0] id,
                           input logic [15:0] len, input logic [7:0] pb, input bit keep,
                           output int n);
    if (!calm && !hold_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    msg_class      <= cls;
    msg_id         <= id;
    payload_length <= len;
    payload_byte   <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
    predict_frame_bytes(op, cls, id, len, pb, keep, n);
  endtask

  initial begin : stimulus
    stim_row_t row;
    int        n;
    int        k;
    int        i;
    int        sent;
    int        pick;
    int        body;
    int        target_len;

    // typed, count, bytes, frame_end on last, opcode, class, id, length, payload
    dir_rows.push_back('{1'b1, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF});
    dir_rows.push_back('{1'b1, 4'd8, 64'h0000_0000_0000_62B5, 1'b1,
                         OP_HEADER, 8'h00, 8'h00, 16'h0000, 8'h00});
    dir_rows.push_back('{1'b1, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'h5A});
    dir_rows.push_back('{1'b1, 4'd6, 64'h0000_FFFF_FFFF_62B5, 1'b0,
                         OP_HEADER, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF});
    // A new header while the long frame is still open abandons it.
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_HEADER, 8'h01, 8'h02, 16'h0001, 8'hFF});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hAB});
    dir_rows.push_back('{1'b1, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h33});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_HEADER, 8'h06, 8'h01, 16'h0003, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h10});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h20});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h30});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_HEADER, 8'h0A, 8'h0B, 16'h0002, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_HEADER, 8'h7F, 8'h80, 16'h0000, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_HEADER, 8'h55, 8'hAA, 16'h8100, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hC3});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_HEADER, 8'h12, 8'h34, 16'h0001, 8'h00});
    dir_rows.push_back('{1'b0, 4'd0, 64'h0, 1'b0, OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      send_item(row.op, row.cls, row.id, row.len, row.pb, !row.typed, n);
      if (row.typed) begin
        for (k = 0; k < row.n_typed; k++)
          tx_expected_q.push_back('{row.typed_tx[8*k +: 8],
                                    row.typed_last && (k == row.n_typed - 1)});
      end
    end

    // Mostly complete frames with random content; some are cut short and
    // abandoned, and a few payload beats land outside any frame.
    sent = 0;
    while (sent < ITEM_TARGET) begin
      if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(OP_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 1'b1, n);
        if (n != 0) sent++;
      end else begin
        if (pick == 1) target_len = $urandom_range(0, 65535);
        else if (pick == 2) target_len = $urandom_range(7, 24);
        else target_len = $urandom_range(0, 6);
        send_item(OP_HEADER, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  target_len[15:0], 8'($urandom_range(0, 255)), 1'b1, n);
        sent++;
        if (pick == 1 || $urandom_range(0, 9) == 0) body = $urandom_range(0, 4);
        else body = target_len;
        for (k = 0; k < body; k++) begin
          send_item(OP_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 1'b1, n);
          if (n != 0) sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (tx_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver pacing: random stall bursts, one long hold early in the random
  // part so the block backs up into its input, and none near the end.
  initial begin : rx_pacing
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held_long && beats_in >= 30) begin
        hold_on = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_on   = 1'b0;
        held_long = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : tx_check
    tx_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tx_expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, tx_byte=%02h frame_end=%0b",
                 $time, tx_byte, frame_end);
      end else begin
        want = tx_expected_q.pop_front();
        if (tx_byte !== want.tx) begin
          errors++;
          $display("%0t: tx_byte expected %02h, got %02h", $time, want.tx, tx_byte);
        end
        if (frame_end !== want.last) begin
          errors++;
          $display("%0t: frame_end expected %0b, got %0b", $time, want.last, frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
design/fmb_pkg.sv
design/framed_message_builder_fletcher8.sv
test/tb_top.sv
